// File: hdl/mrgs_pkg.sv
package mrgs_pkg;

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,      // take items into the element buffer
        OP_INIT,      // width = 1, data in element buffer
        OP_PASS,      // base = 0
        OP_SEG,       // set up one pair of runs and prefetch their heads
        OP_MERGE,     // move one element to the destination buffer
        OP_NEXTSEG,   // base = end of this pair
        OP_FLIP,      // width doubles, buffers swap roles
        OP_OUT_INIT,  // prefetch the first sorted element
        OP_EMIT,      // feed the output register
        OP_CLEAR      // ready for the next run
    } op_t;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_STAY_LOAD,
        C_WIDTH_GE_N,
        C_MERGE_MORE,
        C_END_LT_N,
        C_EMIT_MORE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam logic [PC_W-1:0] STEP_LOAD     = 4'd0;
    localparam logic [PC_W-1:0] STEP_INIT     = 4'd1;
    localparam logic [PC_W-1:0] STEP_CHECK    = 4'd2;
    localparam logic [PC_W-1:0] STEP_PASS     = 4'd3;
    localparam logic [PC_W-1:0] STEP_SEG      = 4'd4;
    localparam logic [PC_W-1:0] STEP_MERGE    = 4'd5;
    localparam logic [PC_W-1:0] STEP_NEXTSEG  = 4'd6;
    localparam logic [PC_W-1:0] STEP_FLIP     = 4'd7;
    localparam logic [PC_W-1:0] STEP_OUT_INIT = 4'd8;
    localparam logic [PC_W-1:0] STEP_EMIT     = 4'd9;
    localparam logic [PC_W-1:0] STEP_CLEAR    = 4'd10;

    // microprogram: jump to target when the condition holds, else fall through
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            STEP_LOAD:     w = '{OP_LOAD,     C_STAY_LOAD,  STEP_LOAD};
            STEP_INIT:     w = '{OP_INIT,     C_NONE,       STEP_LOAD};
            STEP_CHECK:    w = '{OP_NOP,      C_WIDTH_GE_N, STEP_OUT_INIT};
            STEP_PASS:     w = '{OP_PASS,     C_NONE,       STEP_LOAD};
            STEP_SEG:      w = '{OP_SEG,      C_NONE,       STEP_LOAD};
            STEP_MERGE:    w = '{OP_MERGE,    C_MERGE_MORE, STEP_MERGE};
            STEP_NEXTSEG:  w = '{OP_NEXTSEG,  C_END_LT_N,   STEP_SEG};
            STEP_FLIP:     w = '{OP_FLIP,     C_ALWAYS,     STEP_CHECK};
            STEP_OUT_INIT: w = '{OP_OUT_INIT, C_NONE,       STEP_LOAD};
            STEP_EMIT:     w = '{OP_EMIT,     C_EMIT_MORE,  STEP_EMIT};
            STEP_CLEAR:    w = '{OP_CLEAR,    C_ALWAYS,     STEP_LOAD};
            default:       w = '{OP_NOP,      C_ALWAYS,     STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/merge_sorter.sv
// Channel  | Ports                                          | Direction
// ---------+------------------------------------------------+----------
// input    | s_valid s_ready s_value s_last                  | in
// result   | m_valid m_ready m_sorted_value m_final_res      | out
//          | m_overflow                                     |
//
// Items are taken while loading. After the item with last set, the sort runs
// ceil(log2 n) merge passes; each merge step moves one element through the
// single write port of the destination buffer. Further steps set up the sort
// and fetch the first sorted element. Results then leave at one per cycle while
// the receiver takes them, then the sequencer returns to loading. Reset clears the
// sequencer, element count, drop flag, buffer select and output valid, not the buffers.
// A stalled result holds in the output register and the sequencer waits on it.
module merge_sorter #(
    parameter int CAPACITY  = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [DATA_BITS-1:0] s_value,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_BITS-1:0] m_sorted_value,
    output logic                        m_final_res,
    output logic                        m_overflow
);
    import mrgs_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = ADDR_W + 1;

    logic [DATA_BITS-1:0] elem_mem [CAPACITY];
    logic [DATA_BITS-1:0] scr_mem  [CAPACITY];
    logic [DATA_BITS-1:0] elem_rd_a_reg, elem_rd_b_reg, scr_rd_a_reg, scr_rd_b_reg;

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] a_reg, a_next, mid_reg, mid_next;
    logic [CNT_W-1:0] b_reg, b_next, end_reg, end_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_sel_reg, src_sel_next;
    logic             m_valid_reg, m_valid_next;
    logic [DATA_BITS-1:0] m_data_reg, m_data_next;
    logic             m_final_reg, m_final_next;
    logic             m_ovf_reg, m_ovf_next;

    ctrl_t            ctrl;
    logic             cond_hit;
    logic             elem_we, scr_we;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic [DATA_BITS-1:0] wr_data;
    logic signed [DATA_BITS-1:0] rd_a, rd_b;
    logic             take_a, a_ok, b_ok, can_load, last_out;
    logic [CNT_W:0]   mid_sum, end_sum, k_inc;

    assign ctrl = ucode_rom(pc_reg);
    assign s_ready = (ctrl.op == OP_LOAD);

    assign rd_a = src_sel_reg ? scr_rd_a_reg : elem_rd_a_reg;
    assign rd_b = src_sel_reg ? scr_rd_b_reg : elem_rd_b_reg;

    assign a_ok     = (a_reg < mid_reg);
    assign b_ok     = (b_reg < end_reg);
    assign take_a   = a_ok && (!b_ok || (rd_a <= rd_b));
    assign k_inc    = {1'b0, k_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign mid_sum  = {1'b0, base_reg} + {1'b0, width_reg};
    assign end_sum  = {1'b0, base_reg} + {width_reg, 1'b0};
    assign can_load = !m_valid_reg || m_ready;
    assign last_out = (k_inc == {1'b0, count_reg});

    always_comb begin
        pc_next      = pc_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        base_next    = base_reg;
        a_next       = a_reg;
        mid_next     = mid_reg;
        b_next       = b_reg;
        end_next     = end_reg;
        k_next       = k_reg;
        src_sel_next = src_sel_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        m_final_next = m_final_reg;
        m_ovf_next   = m_ovf_reg;
        elem_we      = 1'b0;
        scr_we       = 1'b0;
        wr_addr      = k_reg[ADDR_W-1:0];
        wr_data      = take_a ? rd_a : rd_b;
        rd_addr_a    = a_reg[ADDR_W-1:0];
        rd_addr_b    = b_reg[ADDR_W-1:0];

        unique case (ctrl.op)
            OP_LOAD: begin
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = s_value;
                if (s_valid) begin
                    if (count_reg < CNT_W'(CAPACITY)) begin
                        elem_we    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            OP_INIT: begin
                width_next   = {{(CNT_W-1){1'b0}}, 1'b1};
                src_sel_next = 1'b0;
            end
            OP_PASS: begin
                base_next = '0;
            end
            OP_SEG: begin
                mid_next  = (mid_sum > {1'b0, count_reg}) ? count_reg : mid_sum[CNT_W-1:0];
                end_next  = (end_sum > {1'b0, count_reg}) ? count_reg : end_sum[CNT_W-1:0];
                a_next    = base_reg;
                b_next    = mid_next;
                k_next    = base_reg;
                rd_addr_a = a_next[ADDR_W-1:0];
                rd_addr_b = b_next[ADDR_W-1:0];
            end
            OP_MERGE: begin
                elem_we   = src_sel_reg;
                scr_we    = !src_sel_reg;
                a_next    = a_reg + CNT_W'(take_a);
                b_next    = b_reg + CNT_W'(!take_a);
                k_next    = k_inc[CNT_W-1:0];
                rd_addr_a = a_next[ADDR_W-1:0];
                rd_addr_b = b_next[ADDR_W-1:0];
            end
            OP_NEXTSEG: begin
                base_next = end_reg;
            end
            OP_FLIP: begin
                width_next   = {width_reg[CNT_W-2:0], 1'b0};
                src_sel_next = !src_sel_reg;
            end
            OP_OUT_INIT: begin
                k_next    = '0;
                rd_addr_a = '0;
            end
            OP_EMIT: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_a;
                    m_final_next = last_out;
                    m_ovf_next   = dropped_reg;
                    k_next       = k_inc[CNT_W-1:0];
                    rd_addr_a    = k_inc[ADDR_W-1:0];
                end else begin
                    rd_addr_a = k_reg[ADDR_W-1:0];
                end
            end
            OP_CLEAR: begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            default: begin
            end
        endcase

        case (ctrl.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_STAY_LOAD:  cond_hit = !(s_valid && s_last);
            C_WIDTH_GE_N: cond_hit = (width_reg >= count_reg);
            C_MERGE_MORE: cond_hit = (k_inc < {1'b0, end_reg});
            C_END_LT_N:   cond_hit = (end_reg < count_reg);
            C_EMIT_MORE:  cond_hit = !(can_load && last_out);
            default:      cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[wr_addr] <= wr_data;
        end
        elem_rd_a_reg <= elem_mem[rd_addr_a];
        elem_rd_b_reg <= elem_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[wr_addr] <= wr_data;
        end
        scr_rd_a_reg <= scr_mem[rd_addr_a];
        scr_rd_b_reg <= scr_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            src_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            src_sel_reg <= src_sel_next;
            m_valid_reg <= m_valid_next;
        end
        width_reg   <= width_next;
        base_reg    <= base_next;
        a_reg       <= a_next;
        mid_reg     <= mid_next;
        b_reg       <= b_next;
        end_reg     <= end_next;
        k_reg       <= k_next;
        m_data_reg  <= m_data_next;
        m_final_reg <= m_final_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_data_reg;
    assign m_final_res    = m_final_reg;
    assign m_overflow     = m_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_last_starts_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> (pc_reg == STEP_INIT))
        else $error("last item did not start the sort");

    a_merge_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_MERGE) |-> ((k_reg < end_reg) && (a_ok || b_ok)))
        else $error("merge step outside its pair of runs");

    a_emit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_EMIT) |-> (k_reg < count_reg))
        else $error("emit index beyond stored elements");

endmodule

// File: dv/sort_checker.sv
`timescale 1ns / 1ps

module sort_checker #(
    parameter int CAPACITY  = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [DATA_BITS-1:0] s_value,
    input  logic                        s_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [DATA_BITS-1:0] m_sorted_value,
    input  logic                        m_final_res,
    input  logic                        m_overflow,
    output int                          fail_count,
    output int                          outstanding
);

    typedef struct {
        logic signed [DATA_BITS-1:0] value;
        logic                        final_res;
        logic                        overflow;
    } sorted_item_t;

    logic signed [DATA_BITS-1:0] run_values[$];
    logic                        run_dropped;
    sorted_item_t                sorted_q[$];

    // stable insertion sort of the held run, then queue one result per element
    function automatic void queue_sorted_run();
        logic signed [DATA_BITS-1:0] vals[$];
        logic signed [DATA_BITS-1:0] key;
        sorted_item_t                item;
        int                          j;
        vals = run_values;
        for (int i = 1; i < vals.size(); i++) begin
            key = vals[i];
            j = i - 1;
            // strict compare keeps equal values in arrival order
            while (j >= 0 && vals[j] > key) begin
                vals[j + 1] = vals[j];
                j--;
            end
            vals[j + 1] = key;
        end
        for (int k = 0; k < vals.size(); k++) begin
            item.value     = vals[k];
            item.final_res = (k == vals.size() - 1);
            item.overflow  = run_dropped;
            sorted_q.push_back(item);
        end
        run_values.delete();
        run_dropped = 1'b0;
    endfunction

    always @(posedge aclk) begin
        sorted_item_t want;
        if (!aresetn) begin
            run_values.delete();
            sorted_q.delete();
            run_dropped = 1'b0;
            fail_count  = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (run_values.size() < CAPACITY)
                    run_values.push_back(s_value);
                else
                    run_dropped = 1'b1;
                if (s_last)
                    queue_sorted_run();
            end
            if (m_valid && m_ready) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected item: value %0d final %b overflow %b",
                             $time, m_sorted_value, m_final_res, m_overflow);
                    fail_count++;
                end else begin
                    want = sorted_q.pop_front();
                    if (m_sorted_value !== want.value) begin
                        $display("%0t: sorted_value expected %0d, got %0d",
                                 $time, want.value, m_sorted_value);
                        fail_count++;
                    end
                    if (m_final_res !== want.final_res) begin
                        $display("%0t: final_res expected %b, got %b",
                                 $time, want.final_res, m_final_res);
                        fail_count++;
                    end
                    if (m_overflow !== want.overflow) begin
                        $display("%0t: overflow expected %b, got %b",
                                 $time, want.overflow, m_overflow);
                        fail_count++;
                    end
                end
            end
        end
        outstanding = sorted_q.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY  = 64;
    localparam int DATA_BITS = 32;

    localparam logic signed [DATA_BITS-1:0] VAL_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] VAL_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic signed [DATA_BITS-1:0] s_value        = '0;
    logic                        s_last         = 1'b0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic signed [DATA_BITS-1:0] m_sorted_value;
    logic                        m_final_res;
    logic                        m_overflow;

    int fail_count;
    int outstanding;
    int src_idle    = 0;
    int snk_stall   = 0;
    int hold_req    = 0;

    merge_sorter #(
        .CAPACITY (CAPACITY),
        .DATA_BITS(DATA_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_final_res   (m_final_res),
        .m_overflow    (m_overflow)
    );

    sort_checker #(
        .CAPACITY (CAPACITY),
        .DATA_BITS(DATA_BITS)
    ) chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_final_res   (m_final_res),
        .m_overflow    (m_overflow),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when one is requested
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall);
            end
        end
    end

    function automatic logic signed [DATA_BITS-1:0] pick_value();
        int sel;
        int t;
        sel = $urandom_range(9);
        if (sel < 6)
            return $urandom;
        if (sel < 8) begin
            // narrow range so ties are common
            t = $urandom_range(6);
            return t - 3;
        end
        case ($urandom_range(3))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic signed [DATA_BITS-1:0] v, input logic l);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    task automatic random_runs(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_run(len);
            sent += len;
        end
    endtask

    // sender holds off until every queued result has left the block
    task automatic drain();
        s_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: single-element runs, extremes, ties, descending pair
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b1);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(-5, 1'b0);
        send_item(5, 1'b1);
        send_item(3, 1'b0);
        send_item(2, 1'b1);
        drain();

        // no idling; the last two items of the long run are dropped
        random_runs(12);
        send_run(CAPACITY + 2);
        drain();

        // sparse sender
        src_idle = 87;
        random_runs(12);
        drain();

        // slow receiver
        src_idle  = 0;
        snk_stall = 87;
        random_runs(12);
        drain();

        // light idling on both sides
        src_idle  = 14;
        snk_stall = 14;
        random_runs(12);
        drain();

        // receiver holds off while the sender keeps pushing
        src_idle  = 0;
        snk_stall = 0;
        hold_req  = 300;
        send_run(8);
        send_run(8);
        send_run(8);

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
